// ===== sv/wpm_pkg.sv =====
// wpm_pkg: shared constants and types for the wildcard pattern matcher
// used by wildcard_pattern_matcher_core and its port checker
// no dependencies

package wpm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int ROW_W       = PATTERN_MAX + 1;
    localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
    localparam int ADDR_W      = $clog2(PATTERN_MAX);
    localparam int LEN_W       = 7;
    localparam int OP_W        = 2;
    localparam int CH_W        = 8;

    localparam logic [CH_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [CH_W-1:0] ANY_BYTE  = 8'h3F;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_RESTART = 2'd2,
        OP_TEXT    = 2'd3
    } op_t;

endpackage

// ===== sv/wildcard_pattern_matcher_core.sv =====
// wildcard_pattern_matcher_core: streamed text vs stored '?'/'*' pattern
// depends on wpm_pkg
//
//  channel | signals                     | payload
//  --------+-----------------------------+--------------------------------
//  in      | in_valid / in_ready         | op, ch
//  out     | out_valid / out_ready       | match, overflow, pattern_length
//
// one transaction in, one transaction out; the result is registered, valid in the cycle after acceptance
// one transaction accepted per cycle while the result is being taken; the row update is a 66-bit add carry chain
// in_ready is high while the result register is empty or being taken
// a stalled result holds the input side off; no clearing pass after reset
// reset: empty pattern, empty text, result register empty

module wildcard_pattern_matcher_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [wpm_pkg::OP_W-1:0]  op,
    input  logic [wpm_pkg::CH_W-1:0]  ch,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      match,
    output logic                      overflow,
    output logic [wpm_pkg::LEN_W-1:0] pattern_length
);

    logic [wpm_pkg::CH_W-1:0]  store_reg [wpm_pkg::PATTERN_MAX];
    logic [wpm_pkg::CNT_W-1:0] count_reg, count_next;
    logic [wpm_pkg::CNT_W-1:0] lead_reg, lead_next;
    logic                      all_star_reg, all_star_next;
    logic [wpm_pkg::ROW_W-1:0] row_reg, row_next;

    logic                      out_valid_reg;
    logic                      match_reg, match_next;
    logic                      overflow_reg, overflow_next;
    logic [wpm_pkg::LEN_W-1:0] length_reg;

    logic                      in_fire;
    logic                      full;
    logic                      store_we;
    logic [wpm_pkg::ROW_W-1:0] gen_vec, prop_vec, fed_row, empty_row;
    logic [wpm_pkg::ROW_W:0]   add_a, add_b, add_sum, carry_vec;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign full     = (count_reg == wpm_pkg::CNT_W'(wpm_pkg::PATTERN_MAX));

    // generate / propagate per column, star columns propagate the new left bit
    always_comb
    begin
        gen_vec  = '0;
        prop_vec = '0;
        for (int j = 1; j <= wpm_pkg::PATTERN_MAX; j++)
        begin
            if (wpm_pkg::CNT_W'(j) <= count_reg)
            begin
                if (store_reg[j-1] == wpm_pkg::STAR_BYTE)
                begin
                    prop_vec[j] = 1'b1;
                    gen_vec[j]  = row_reg[j];
                end
                else if (store_reg[j-1] == wpm_pkg::ANY_BYTE || store_reg[j-1] == ch)
                begin
                    gen_vec[j] = row_reg[j-1];
                end
            end
        end
    end

    assign add_a     = {1'b0, gen_vec | prop_vec};
    assign add_b     = {1'b0, gen_vec};
    assign add_sum   = add_a + add_b;
    assign carry_vec = add_sum ^ add_a ^ add_b;
    assign fed_row   = carry_vec[wpm_pkg::ROW_W:1];

    always_comb
    begin
        count_next    = count_reg;
        lead_next     = lead_reg;
        all_star_next = all_star_reg;
        overflow_next = 1'b0;
        store_we      = 1'b0;
        unique case (wpm_pkg::op_t'(op))
            wpm_pkg::OP_CLEAR:
            begin
                count_next    = '0;
                lead_next     = '0;
                all_star_next = 1'b1;
            end
            wpm_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    store_we   = 1'b1;
                    count_next = count_reg + wpm_pkg::CNT_W'(1);
                    if (all_star_reg && ch == wpm_pkg::STAR_BYTE)
                        lead_next = lead_reg + wpm_pkg::CNT_W'(1);
                    else
                        all_star_next = 1'b0;
                end
            end
            wpm_pkg::OP_RESTART:
            begin
            end
            wpm_pkg::OP_TEXT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int j = 0; j <= wpm_pkg::PATTERN_MAX; j++)
            empty_row[j] = (wpm_pkg::CNT_W'(j) <= lead_next);
    end

    always_comb
    begin
        row_next = row_reg;
        unique case (wpm_pkg::op_t'(op))
            wpm_pkg::OP_CLEAR:   row_next = empty_row;
            wpm_pkg::OP_APPEND:  row_next = full ? row_reg : empty_row;
            wpm_pkg::OP_RESTART: row_next = empty_row;
            wpm_pkg::OP_TEXT:    row_next = fed_row;
            default:             row_next = row_reg;
        endcase
        match_next = row_next[count_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            lead_reg     <= '0;
            all_star_reg <= 1'b1;
            row_reg      <= wpm_pkg::ROW_W'(1);
        end
        else if (in_fire)
        begin
            count_reg    <= count_next;
            lead_reg     <= lead_next;
            all_star_reg <= all_star_next;
            row_reg      <= row_next;
        end
    end

    // pattern store, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire && store_we)
            store_reg[count_reg[wpm_pkg::ADDR_W-1:0]] <= ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            match_reg    <= match_next;
            overflow_reg <= overflow_next;
            length_reg   <= wpm_pkg::LEN_W'(count_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign match          = match_reg;
    assign overflow       = overflow_reg;
    assign pattern_length = length_reg;

endmodule

// ===== sv/wpm_port_check.sv =====
// wpm_port_check: port-level checks for wildcard_pattern_matcher_core
// depends on wpm_pkg; bound to wildcard_pattern_matcher_core below

module wpm_port_check (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      match,
    input logic                      overflow,
    input logic [wpm_pkg::LEN_W-1:0] pattern_length
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(match)
            && $stable(overflow) && $stable(pattern_length))
        else $error("result changed while stalled");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    a_in_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted transaction produced no result");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            pattern_length == wpm_pkg::LEN_W'(wpm_pkg::PATTERN_MAX))
        else $error("overflow with store not full");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pattern_length <= wpm_pkg::LEN_W'(wpm_pkg::PATTERN_MAX))
        else $error("pattern length out of range");

endmodule

bind wildcard_pattern_matcher_core wpm_port_check u_wpm_port_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .match          (match),
    .overflow       (overflow),
    .pattern_length (pattern_length)
);
